// ===== sv/lruc_pkg.sv =====
// shared types and constants for the reuse-count admission unit
`default_nettype none
package lruc_pkg;

  localparam int KEY_W    = 64;
  localparam int OUT_CNT_W = 16;
  localparam int THR_W    = 16;
  localparam int LIM_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = 16'hFFFF;
  localparam logic [THR_W-1:0]     TRACK_MIN   = 16'd2;
  localparam logic [THR_W-1:0]     THR_RESET   = 16'd1;
  localparam logic [LIM_W-1:0]     LIM_RESET   = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_ADMIT_THR     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKER_LIMIT = 1'b1;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_STORE  = 1'b1;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
  } lruc_in_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 admit;
    logic                 dropped_oldest;
  } lruc_out_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic shift_all;
    logic shift_hit;
    logic wr_en;
  } lruc_ctl_t;

endpackage
`default_nettype wire

// ===== sv/lruc_cell.sv =====
// one slot of the recency chain: key, count, compare and shift logic
`default_nettype none
module lruc_cell import lruc_pkg::*; #(
  parameter int IDX        = 0,
  parameter int KEY_BITS   = 64,
  parameter int COUNT_BITS = 16,
  parameter int OCC_W      = 7,
  parameter int IDX_W      = 6
) (
  input  wire logic                  clk,
  input  wire logic [OCC_W-1:0]      occ,
  input  wire logic [KEY_BITS-1:0]   req_key,
  input  wire lruc_ctl_t             ctl,
  input  wire logic [IDX_W-1:0]      wr_idx,
  input  wire logic [COUNT_BITS-1:0] wr_cnt,
  input  wire logic [KEY_BITS-1:0]   nb_key,
  input  wire logic [COUNT_BITS-1:0] nb_cnt,
  input  wire logic                  below_in,
  output logic                       below_out,
  input  wire logic [COUNT_BITS-1:0] acc_in,
  output logic [COUNT_BITS-1:0]      acc_out,
  output logic [KEY_BITS-1:0]        key_q,
  output logic [COUNT_BITS-1:0]      cnt_q
);

  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  match_r, match_nxt;
  logic                  live;
  logic                  take_nb;
  logic                  wr_here;

  assign live      = OCC_W'(IDX) < occ;
  assign match_nxt = live && (key_r == req_key);

  // a hit at or below this slot pulls the upper entries down by one
  assign below_out = below_in | match_r;
  assign acc_out   = acc_in | (match_r ? cnt_r : '0);

  assign take_nb = ctl.shift_all | (ctl.shift_hit & below_out);
  assign wr_here = ctl.wr_en && (wr_idx == IDX_W'(IDX));

  always_comb begin
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    if (wr_here) begin
      key_nxt = req_key;
      cnt_nxt = wr_cnt;
    end else if (take_nb) begin
      key_nxt = nb_key;
      cnt_nxt = nb_cnt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    cnt_r   <= cnt_nxt;
    match_r <= match_nxt;
  end

  assign key_q = key_r;
  assign cnt_q = cnt_r;

endmodule
`default_nettype wire

// ===== sv/lru_reuse_counter_admission_unit.sv =====
// reuse-count admission unit: recency-ordered key table as a chain of cells
//
// input channel in_valid/in_stall/in_data carries one transaction per item:
// func selects lookup (bump the key) or store check (read count, decide
// admit), key names the block. the result channel out_valid/out_stall/
// out_data returns one transaction per item in order: count, admit and
// dropped_oldest. cfg_we/cfg_idx/cfg_wdata write the admit threshold (index 0)
// and tracker_limit (index 1); the user must write them only while no item
// is in flight, the block itself does not enforce this. an accepted item
// walks compare, gather (hit/count collection along the chain) and shifting
// update steps through the cell chain; its result is registered onto out_valid
// when the update completes. in_stall stays high from the compare step until
// then, so no new item is taken while one is in flight.
// the result sits in an output register; while the receiver stalls it holds
// and the next item may already be accepted, but its update step waits
// until the register is free.
// reset (rst_n low, synchronous) empties the table, drops any pending
// result and restores threshold 1 and limit 64; no clearing pass is needed.
`default_nettype none
module lru_reuse_counter_admission_unit import lruc_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int KEY_BITS   = 64,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire lruc_in_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lruc_out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [THR_W-1:0]     cfg_wdata
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LW    = (OCC_W > LIM_W) ? OCC_W : LIM_W;
  localparam int CW0   = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
  localparam int CW    = (CW0 > THR_W) ? CW0 : THR_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_GATH = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [THR_W-1:0]      thr_r, thr_nxt;
  logic [LIM_W-1:0]      lim_r, lim_nxt;
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  logic                  func_r, func_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic                  hit_r, hit_nxt;
  logic [COUNT_BITS-1:0] hcnt_r, hcnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lruc_out_t             out_data_r, out_data_nxt;

  logic [KEY_BITS-1:0]   cell_key [DEPTH];
  logic [COUNT_BITS-1:0] cell_cnt [DEPTH];
  logic [KEY_BITS-1:0]   nb_key   [DEPTH];
  logic [COUNT_BITS-1:0] nb_cnt   [DEPTH];
  logic                  below    [DEPTH+1];
  logic [COUNT_BITS-1:0] acc      [DEPTH+1];

  lruc_ctl_t             ctl;
  logic [IDX_W-1:0]      wr_idx;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  accept;
  logic                  out_free;
  logic                  fire;
  logic                  tracking;
  logic                  upd;
  logic                  drop;
  logic [LW-1:0]         eff_lim;
  logic [LW-1:0]         occ_w;
  logic [CW-1:0]         res_cnt;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = (state_r == S_UPD) && out_free;

  assign below[0] = 1'b0;
  assign acc[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_top
      assign nb_key[i] = '0;
      assign nb_cnt[i] = '0;
    end else begin : g_mid
      assign nb_key[i] = cell_key[i+1];
      assign nb_cnt[i] = cell_cnt[i+1];
    end

    lruc_cell #(
      .IDX        (i),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS),
      .OCC_W      (OCC_W),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk       (clk),
      .occ       (occ_r),
      .req_key   (key_r),
      .ctl       (ctl),
      .wr_idx    (wr_idx),
      .wr_cnt    (new_cnt),
      .nb_key    (nb_key[i]),
      .nb_cnt    (nb_cnt[i]),
      .below_in  (below[i]),
      .below_out (below[i+1]),
      .acc_in    (acc[i]),
      .acc_out   (acc[i+1]),
      .key_q     (cell_key[i]),
      .cnt_q     (cell_cnt[i])
    );
  end

  // limit of zero acts as one, above the table size it saturates
  always_comb begin
    eff_lim = LW'(lim_r);
    if (lim_r == '0) begin
      eff_lim = LW'(1);
    end else if (LW'(lim_r) > LW'(DEPTH)) begin
      eff_lim = LW'(DEPTH);
    end
  end

  assign occ_w    = LW'(occ_r);
  assign tracking = thr_r >= TRACK_MIN;
  assign upd      = (func_r == FUNC_LOOKUP) && tracking;
  assign drop     = upd && !hit_r && (occ_w >= eff_lim) && (occ_r != '0);
  assign new_cnt  = hit_r ? ((hcnt_r == '1) ? hcnt_r : hcnt_r + 1'b1)
                          : COUNT_BITS'(1);

  always_comb begin
    ctl.shift_hit = fire && upd && hit_r;
    ctl.shift_all = fire && drop;
    ctl.wr_en     = fire && upd;
    if (hit_r || drop) begin
      wr_idx = IDX_W'(occ_r - 1'b1);
    end else begin
      wr_idx = IDX_W'(occ_r);
    end
  end

  assign res_cnt = upd ? CW'(new_cnt) : CW'(hcnt_r);

  always_comb begin
    state_nxt     = state_r;
    thr_nxt       = thr_r;
    lim_nxt       = lim_r;
    occ_nxt       = occ_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    hit_nxt       = hit_r;
    hcnt_nxt      = hcnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ADMIT_THR:     thr_nxt = cfg_wdata;
        CFG_TRACKER_LIMIT: lim_nxt = cfg_wdata[LIM_W-1:0];
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt  = in_data.func;
          key_nxt   = KEY_BITS'(in_data.key);
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_GATH;
      end
      S_GATH: begin
        hit_nxt   = below[DEPTH];
        hcnt_nxt  = acc[DEPTH];
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          if (upd && !hit_r && !drop) begin
            occ_nxt = occ_r + 1'b1;
          end
          out_valid_nxt       = 1'b1;
          out_data_nxt.count  = (res_cnt > CW'(OUT_CNT_MAX)) ? OUT_CNT_MAX
                                                             : res_cnt[OUT_CNT_W-1:0];
          out_data_nxt.admit  = (func_r == FUNC_STORE) &&
                                (!tracking || (CW'(hcnt_r) >= CW'(thr_r)));
          out_data_nxt.dropped_oldest = drop;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_RESET;
      lim_r       <= LIM_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      lim_r       <= lim_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    hit_r      <= hit_nxt;
    hcnt_r     <= hcnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== sv/lruc_chk.sv =====
// port-level checks for the reuse-count admission unit, bound to the top level
`default_nettype none
module lruc_chk import lruc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire lruc_out_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // only a lookup drops, only a store check admits
  a_admit_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.admit && out_data.dropped_oldest))
    else $error("admit and dropped_oldest both set");

  // a drop only happens on insert of a new key, which starts at one
  a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped_oldest |-> out_data.count == 16'd1)
    else $error("drop with count other than one");

  // one item in flight: busy right after an accepted transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind lru_reuse_counter_admission_unit lruc_chk u_lruc_chk (.*);
`default_nettype wire
